[hw/rtl/ihex_pkg.sv]
// Shared types, codes and constants for the Intel HEX record parser.
`timescale 1ns / 1ps

package ihex_pkg;

    localparam int MAX_LINE = 512;
    localparam logic [12:0] LINE_LIMIT = 13'(MAX_LINE - 1);
    localparam logic [10:0] BLOCK_CAP = 11'd1024;
    localparam logic [10:0] BLOCK_LIMIT_RESET = 11'd64;

    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_COLON = 8'h3A;

    // Status codes of a result.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_CHECKSUM = 3'd1;
    localparam logic [2:0] ST_SHORT    = 3'd2;
    localparam logic [2:0] ST_BAD_CNT  = 3'd3;
    localparam logic [2:0] ST_UNKNOWN  = 3'd4;
    localparam logic [2:0] ST_BLOCKS   = 3'd5;
    localparam logic [2:0] ST_BAD_HEX  = 3'd6;

    // Record types.
    localparam logic [7:0] REC_DATA    = 8'd0;
    localparam logic [7:0] REC_EOF     = 8'd1;
    localparam logic [7:0] REC_SEG     = 8'd2;
    localparam logic [7:0] REC_SSA     = 8'd3;
    localparam logic [7:0] REC_LIN     = 8'd4;
    localparam logic [7:0] REC_START   = 8'd5;

    localparam logic [0:0] KIND_BYTE   = 1'b0;
    localparam logic [0:0] KIND_RECORD = 1'b1;

    typedef enum logic [1:0] {
        TOK_OTHER,
        TOK_NL,
        TOK_COLON,
        TOK_HEX
    } tok_kind_t;

    typedef struct packed {
        tok_kind_t  kind;
        logic [3:0] nib;
    } token_t;

    typedef enum logic [3:0] {
        MODE_START  = 4'b0001,
        MODE_RECORD = 4'b0010,
        MODE_SKIP   = 4'b0100,
        MODE_DONE   = 4'b1000
    } line_mode_t;

    typedef struct packed {
        logic [0:0]  kind;
        logic [31:0] address;
        logic [7:0]  data_byte;
        logic [7:0]  record_type;
        logic [2:0]  status;
        logic        new_block;
        logic [9:0]  block_index;
        logic [7:0]  byte_count;
        logic        halted;
    } result_t;

endpackage

[hw/rtl/ihex_front.sv]
// Front end: accepts characters and classifies them into tokens.
`timescale 1ns / 1ps

module ihex_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [7:0]      s_ch,
    output logic            tok_valid,
    output ihex_pkg::token_t tok,
    input  logic            tok_ready
);
    import ihex_pkg::*;

    logic   tok_valid_reg;
    token_t tok_reg;
    token_t tok_next;

    always_comb begin
        tok_next.nib = 4'd0;
        if (s_ch >= 8'h30 && s_ch <= 8'h39) begin
            tok_next.kind = TOK_HEX;
            tok_next.nib  = 4'(s_ch - 8'h30);
        end else if (s_ch >= 8'h41 && s_ch <= 8'h46) begin
            tok_next.kind = TOK_HEX;
            tok_next.nib  = 4'(s_ch - 8'h37);
        end else if (s_ch >= 8'h61 && s_ch <= 8'h66) begin
            tok_next.kind = TOK_HEX;
            tok_next.nib  = 4'(s_ch - 8'h57);
        end else if (s_ch == CHAR_NL) begin
            tok_next.kind = TOK_NL;
        end else if (s_ch == CHAR_COLON) begin
            tok_next.kind = TOK_COLON;
        end else begin
            tok_next.kind = TOK_OTHER;
        end
    end

    assign s_ready   = !tok_valid_reg || tok_ready;
    assign tok_valid = tok_valid_reg;
    assign tok       = tok_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_valid_reg <= 1'b0;
        end else if (s_ready) begin
            tok_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            tok_reg <= tok_next;
        end
    end

endmodule

[hw/rtl/ihex_queue.sv]
// Four-entry token queue between the front end and the record engine.
`timescale 1ns / 1ps

module ihex_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  ihex_pkg::token_t push_tok,
    output logic             pop_valid,
    input  logic             pop_ready,
    output ihex_pkg::token_t pop_tok
);
    import ihex_pkg::*;

    token_t     slot_reg [4];
    logic [1:0] wr_ptr_reg;
    logic [1:0] rd_ptr_reg;
    logic [2:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 3'd4);
    assign pop_valid  = (count_reg != 3'd0);
    assign pop_tok    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 3'd1;
            end else if (!do_push && do_pop) begin
                count_reg <= count_reg - 3'd1;
            end
        end
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_tok;
        end
    end

endmodule

[hw/rtl/ihex_back.sv]
// Record engine: decodes tokens, tracks bases and blocks, and registers results.
`timescale 1ns / 1ps

module ihex_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              tok_valid,
    output logic              tok_ready,
    input  ihex_pkg::token_t  tok,
    input  logic [10:0]       block_limit,
    output logic              res_valid,
    input  logic              res_ready,
    output ihex_pkg::result_t res
);
    import ihex_pkg::*;

    line_mode_t  mode_reg,   mode_next;
    logic [9:0]  pos_reg,    pos_next;
    logic [3:0]  hn_reg,     hn_next;
    logic [7:0]  count_reg,  count_next;
    logic [15:0] offset_reg, offset_next;
    logic [7:0]  kind_reg,   kind_next;
    logic [7:0]  sum_reg,    sum_next;
    logic [31:0] collect_reg, collect_next;
    logic [31:0] base_reg,   base_next;
    logic [10:0] bc_reg,     bc_next;
    logic [31:0] bend_reg,   bend_next;
    logic        halt_reg,   halt_next;
    logic        out_valid_reg;
    result_t     out_reg;

    logic        take;
    logic        emit;
    result_t     emit_res;
    logic [7:0]  b;
    logic [8:0]  k;
    logic [8:0]  idx;
    logic [31:0] rec_addr;
    logic [10:0] limit;

    function automatic result_t mk_res(logic [0:0] kd, logic [31:0] addr, logic [7:0] db,
                                       logic [7:0] rt, logic [2:0] st, logic nb,
                                       logic [9:0] bi, logic [7:0] cnt);
        result_t r;
        r.kind        = kd;
        r.address     = addr;
        r.data_byte   = db;
        r.record_type = rt;
        r.status      = st;
        r.new_block   = nb;
        r.block_index = bi;
        r.byte_count  = cnt;
        r.halted      = (st != ST_OK);
        return r;
    endfunction

    assign take      = tok_valid && (!out_valid_reg || res_ready);
    assign tok_ready = !out_valid_reg || res_ready;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    assign b        = {hn_reg, tok.nib};
    assign k        = pos_reg[9:1];
    assign idx      = k - 9'd4;
    assign rec_addr = base_reg + {16'd0, offset_reg};
    assign limit    = (block_limit > BLOCK_CAP) ? BLOCK_CAP : block_limit;

    always_comb begin
        mode_next    = mode_reg;
        pos_next     = pos_reg;
        hn_next      = hn_reg;
        count_next   = count_reg;
        offset_next  = offset_reg;
        kind_next    = kind_reg;
        sum_next     = sum_reg;
        collect_next = collect_reg;
        base_next    = base_reg;
        bc_next      = bc_reg;
        bend_next    = bend_reg;
        halt_next    = halt_reg;
        emit         = 1'b0;
        emit_res     = '0;
        if (take && !halt_reg) begin
            unique case (mode_reg) inside
                MODE_START: begin
                    if (tok.kind == TOK_COLON) begin
                        mode_next    = MODE_RECORD;
                        pos_next     = 10'd0;
                        hn_next      = 4'd0;
                        count_next   = 8'd0;
                        offset_next  = 16'd0;
                        kind_next    = 8'd0;
                        sum_next     = 8'd0;
                        collect_next = 32'd0;
                    end else if (tok.kind != TOK_NL) begin
                        mode_next = MODE_SKIP;
                    end
                end
                MODE_SKIP, MODE_DONE: begin
                    if (tok.kind == TOK_NL) begin
                        mode_next = MODE_START;
                    end
                end
                MODE_RECORD: begin
                    if (tok.kind == TOK_NL) begin
                        mode_next = MODE_START;
                        emit      = 1'b1;
                        emit_res  = mk_res(KIND_RECORD, 32'd0, 8'd0, kind_reg, ST_SHORT,
                                           1'b0, 10'd0, count_reg);
                    end else if (tok.kind != TOK_HEX) begin
                        emit     = 1'b1;
                        emit_res = mk_res(KIND_RECORD, 32'd0, 8'd0, kind_reg, ST_BAD_HEX,
                                          1'b0, 10'd0, count_reg);
                    end else if (!pos_reg[0]) begin
                        hn_next  = tok.nib;
                        pos_next = pos_reg + 10'd1;
                    end else begin
                        pos_next = pos_reg + 10'd1;
                        sum_next = sum_reg + b;
                        if (k == 9'd0) begin
                            count_next = b;
                            // Reject a count whose line could not fit in the line buffer.
                            if ({4'd0, b, 1'b0} + 13'd11 > LINE_LIMIT) begin
                                emit     = 1'b1;
                                emit_res = mk_res(KIND_RECORD, 32'd0, 8'd0, kind_reg,
                                                  ST_SHORT, 1'b0, 10'd0, b);
                            end
                        end else if (k == 9'd1 || k == 9'd2) begin
                            offset_next = {offset_reg[7:0], b};
                        end else if (k == 9'd3) begin
                            kind_next = b;
                        end else if (idx < {1'b0, count_reg}) begin
                            collect_next = {collect_reg[23:0], b};
                            if (kind_reg == REC_DATA) begin
                                emit     = 1'b1;
                                emit_res = mk_res(KIND_BYTE, rec_addr + {23'd0, idx}, b,
                                                  8'd0, ST_OK, 1'b0, 10'd0, count_reg);
                            end
                        end else begin
                            // Checksum byte: the record is complete.
                            emit = 1'b1;
                            if (sum_reg + b != 8'd0) begin
                                emit_res = mk_res(KIND_RECORD, 32'd0, 8'd0, kind_reg,
                                                  ST_CHECKSUM, 1'b0, 10'd0, count_reg);
                            end else begin
                                case (kind_reg) inside
                                    REC_DATA: begin
                                        if (bc_reg == 11'd0) begin
                                            bc_next   = 11'd1;
                                            bend_next = rec_addr + {24'd0, count_reg};
                                            emit_res  = mk_res(KIND_RECORD, rec_addr, 8'd0,
                                                               kind_reg, ST_OK, 1'b1, 10'd0,
                                                               count_reg);
                                        end else if (bend_reg != rec_addr) begin
                                            if (bc_reg + 11'd1 < limit) begin
                                                bc_next   = bc_reg + 11'd1;
                                                bend_next = rec_addr + {24'd0, count_reg};
                                                emit_res  = mk_res(KIND_RECORD, rec_addr,
                                                                   8'd0, kind_reg, ST_OK,
                                                                   1'b1, bc_reg[9:0],
                                                                   count_reg);
                                            end else begin
                                                emit_res = mk_res(KIND_RECORD, rec_addr,
                                                                  8'd0, kind_reg, ST_BLOCKS,
                                                                  1'b0, 10'd0, count_reg);
                                            end
                                        end else begin
                                            bend_next = bend_reg + {24'd0, count_reg};
                                            emit_res  = mk_res(KIND_RECORD, rec_addr, 8'd0,
                                                               kind_reg, ST_OK, 1'b0,
                                                               10'(bc_reg - 11'd1), count_reg);
                                        end
                                    end
                                    REC_EOF, REC_SSA: begin
                                        emit_res = mk_res(KIND_RECORD, 32'd0, 8'd0, kind_reg,
                                                          ST_OK, 1'b0, 10'd0, count_reg);
                                    end
                                    REC_SEG, REC_LIN: begin
                                        if (count_reg != 8'd2) begin
                                            emit_res = mk_res(KIND_RECORD, 32'd0, 8'd0,
                                                              kind_reg, ST_BAD_CNT, 1'b0,
                                                              10'd0, count_reg);
                                        end else begin
                                            base_next = (kind_reg == REC_SEG) ?
                                                        {collect_reg[27:0], 4'd0} :
                                                        {collect_reg[15:0], 16'd0};
                                            emit_res  = mk_res(KIND_RECORD, base_next, 8'd0,
                                                               kind_reg, ST_OK, 1'b0, 10'd0,
                                                               count_reg);
                                        end
                                    end
                                    REC_START: begin
                                        if (count_reg != 8'd4) begin
                                            emit_res = mk_res(KIND_RECORD, 32'd0, 8'd0,
                                                              kind_reg, ST_BAD_CNT, 1'b0,
                                                              10'd0, count_reg);
                                        end else begin
                                            emit_res = mk_res(KIND_RECORD, collect_reg, 8'd0,
                                                              kind_reg, ST_OK, 1'b0, 10'd0,
                                                              count_reg);
                                        end
                                    end
                                    default: begin
                                        emit_res = mk_res(KIND_RECORD, 32'd0, 8'd0, kind_reg,
                                                          ST_UNKNOWN, 1'b0, 10'd0, count_reg);
                                    end
                                endcase
                            end
                            if (emit_res.status == ST_OK) begin
                                mode_next = MODE_DONE;
                            end
                        end
                    end
                end
                default: begin
                    mode_next = MODE_START;
                end
            endcase
            if (emit && emit_res.status != ST_OK) begin
                halt_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_START;
            pos_reg       <= 10'd0;
            hn_reg        <= 4'd0;
            count_reg     <= 8'd0;
            offset_reg    <= 16'd0;
            kind_reg      <= 8'd0;
            sum_reg       <= 8'd0;
            collect_reg   <= 32'd0;
            base_reg      <= 32'd0;
            bc_reg        <= 11'd0;
            bend_reg      <= 32'd0;
            halt_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            mode_reg    <= mode_next;
            pos_reg     <= pos_next;
            hn_reg      <= hn_next;
            count_reg   <= count_next;
            offset_reg  <= offset_next;
            kind_reg    <= kind_next;
            sum_reg     <= sum_next;
            collect_reg <= collect_next;
            base_reg    <= base_next;
            bc_reg      <= bc_next;
            bend_reg    <= bend_next;
            halt_reg    <= halt_next;
            if (!out_valid_reg || res_ready) begin
                out_valid_reg <= take && emit;
            end
        end
        if (take && emit) begin
            out_reg <= emit_res;
        end
    end

endmodule

[hw/rtl/intel_hex_record_parser.sv]
// Top level of the streaming Intel HEX record parser.
`timescale 1ns / 1ps

// Streams Intel HEX text one character per request and returns provisional data
// bytes and one status result per record end. The block sustains one character
// per clock cycle while results are taken. The classifier register is loaded
// when a character is accepted, the token passes through the four-entry queue,
// and the record engine then loads the result register. Either side may stall
// on its own: the classifier register and the queue together hold up to five
// characters while the result side waits. After the first error the block
// drains every further character without a result until reset. The block_limit
// register sits at byte address 0 and should be written only while no character
// is in flight.
module intel_hex_record_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_ch,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [0:0]  m_kind,
    output logic [31:0] m_address,
    output logic [7:0]  m_data_byte,
    output logic [7:0]  m_record_type,
    output logic [2:0]  m_status,
    output logic        m_new_block,
    output logic [9:0]  m_block_index,
    output logic [7:0]  m_byte_count,
    output logic        m_halted
);
    import ihex_pkg::*;

    logic [10:0] block_limit_reg;
    logic        front_valid;
    logic        front_ready;
    token_t      front_tok;
    logic        q_valid;
    logic        q_ready;
    token_t      q_tok;
    result_t     res;

    assign pready = 1'b1;
    assign prdata = {21'd0, block_limit_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_limit_reg <= BLOCK_LIMIT_RESET;
        end else if (psel && penable && pwrite && paddr == 2'd0) begin
            block_limit_reg <= pwdata[10:0];
        end
    end

    ihex_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_ch      (s_ch),
        .tok_valid (front_valid),
        .tok       (front_tok),
        .tok_ready (front_ready)
    );

    ihex_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_tok   (front_tok),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_tok    (q_tok)
    );

    ihex_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .tok_valid   (q_valid),
        .tok_ready   (q_ready),
        .tok         (q_tok),
        .block_limit (block_limit_reg),
        .res_valid   (m_valid),
        .res_ready   (m_ready),
        .res         (res)
    );

    assign m_kind        = res.kind;
    assign m_address     = res.address;
    assign m_data_byte   = res.data_byte;
    assign m_record_type = res.record_type;
    assign m_status      = res.status;
    assign m_new_block   = res.new_block;
    assign m_block_index = res.block_index;
    assign m_byte_count  = res.byte_count;
    assign m_halted      = res.halted;

endmodule

[hw/rtl/ihex_checker.sv]
// Port-level checks for the Intel HEX record parser, bound to the top level.
`timescale 1ns / 1ps

module ihex_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [0:0]  m_kind,
    input logic [31:0] m_address,
    input logic [2:0]  m_status,
    input logic        m_new_block,
    input logic        m_halted
);
    import ihex_pkg::*;

    // Once the error result is taken, nothing more comes out until reset.
    a_halt_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_halted |=> !m_valid)
        else $error("result after halting error");

    a_halt_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_halted == (m_status != ST_OK)))
        else $error("halted flag does not match status");

    a_byte_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_BYTE |-> m_status == ST_OK && !m_new_block)
        else $error("data byte result carries record status");

    a_new_block: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_new_block |-> m_kind == KIND_RECORD && m_status == ST_OK)
        else $error("new block on a failed or byte result");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_address))
        else $error("stalled result changed");

endmodule

bind intel_hex_record_parser ihex_checker u_ihex_checker (.*);
